// ===== rtl/core/pidrl_pkg.sv =====
// Shared types and constants for the rate-limited PID controller.
// No dependencies; used by pidrl_mul, the top level and the testbench.
package pidrl_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int IO_W       = 32;
    localparam int GAIN_W     = 24;
    localparam int PERIOD_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // product scaling: gains, weights and period are Q.16, inverse period Q.8
    localparam int QF_GAIN = 16;
    localparam int QF_INV  = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_PERIOD = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE_LIM = 3'd5;

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 24'd65536;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 24'd0;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 24'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd655;
    localparam logic [GAIN_W-1:0]   INV_PERIOD_RST = 24'd25600;
    localparam logic [LIMIT_W-1:0]  SETTLE_LIM_RST = 16'd50;

    // derivative filter weights, Q0.16: 0.9 and 0.1
    localparam logic [GAIN_W-1:0] W_KEEP = 24'd58982;
    localparam logic [GAIN_W-1:0] W_NEW  = 24'd6554;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic start;
        logic narrow;   // scale by 2^-8 instead of 2^-16
    } mul_ctl_t;

endpackage

// ===== rtl/core/pidrl_mul.sv =====
// Digit-serial saturating multiplier: signed data value times unsigned 24-bit
// coefficient, two multiplier bits per cycle, truncated toward zero.
// Depends on pidrl_pkg.
module pidrl_mul import pidrl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mul_ctl_t                     ctl,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic        [GAIN_W-1:0]     g,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result
);

    localparam int DIGITS = (DATA_WIDTH + 1) / 2;
    localparam int MW     = 2 * DIGITS;
    localparam int PW     = GAIN_W + MW;
    localparam int QW     = PW - QF_INV;
    localparam int SW     = GAIN_W + 2;
    localparam int CW     = $clog2(DIGITS);
    localparam logic [CW-1:0] LAST = CW'(DIGITS - 1);
    localparam logic [DATA_WIDTH-1:0] LIM  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_ROUND} mstate_t;

    mstate_t                         state_reg;
    logic        [CW-1:0]            cnt_reg;
    logic        [GAIN_W-1:0]        hi_reg;
    logic        [MW-1:0]            lo_reg;
    logic        [GAIN_W-1:0]        g_reg;
    logic                            neg_reg;
    logic                            narrow_reg;
    logic                            done_reg;
    logic signed [DATA_WIDTH-1:0]    result_reg;

    logic [DATA_WIDTH-1:0] a_u;
    logic [DATA_WIDTH-1:0] mag;
    logic [SW-1:0]         addend;
    logic [SW-1:0]         sum;
    logic [PW-1:0]         product;
    logic [QW-1:0]         q;
    logic                  ovf;
    logic [DATA_WIDTH-1:0] qc;
    logic [DATA_WIDTH-1:0] res;

    always_comb begin
        a_u     = a;
        mag     = a_u[DATA_WIDTH-1] ? (~a_u + DATA_WIDTH'(1)) : a_u;
        addend  = ({2'b00, g_reg} & {SW{lo_reg[0]}})
                + ({1'b0, g_reg, 1'b0} & {SW{lo_reg[1]}});
        sum     = {2'b00, hi_reg} + addend;
        product = {hi_reg, lo_reg};
        q       = narrow_reg ? product[PW-1:QF_INV]
                             : {{(QF_GAIN-QF_INV){1'b0}}, product[PW-1:QF_GAIN]};
        ovf     = |q[QW-1:DATA_WIDTH-1];
        qc      = ovf ? LIM : q[DATA_WIDTH-1:0];
        if (neg_reg) begin
            res = ~qc + DATA_WIDTH'(1);
        end else begin
            res = ovf ? DMAX : qc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (state_reg == M_ROUND);
            unique case (state_reg)
                M_IDLE: begin
                    if (ctl.start) begin
                        lo_reg     <= MW'(mag);
                        hi_reg     <= '0;
                        g_reg      <= g;
                        neg_reg    <= a_u[DATA_WIDTH-1];
                        narrow_reg <= ctl.narrow;
                        cnt_reg    <= '0;
                        state_reg  <= M_RUN;
                    end
                end
                M_RUN: begin
                    hi_reg  <= sum[SW-1:2];
                    lo_reg  <= {sum[1:0], lo_reg[MW-1:2]};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == LAST) begin
                        state_reg <= M_ROUND;
                    end
                end
                M_ROUND: begin
                    result_reg <= res;
                    state_reg  <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/pid_controller_with_rate_limit.sv =====
// Top level of the rate-limited PID controller with dead band, clamped
// integral, filtered derivative and settle detection.
// Depends on pidrl_pkg and pidrl_mul.

// One error sample in, one drive value out. All seven products of a request
// go one after another through a single multiplier that consumes two bits
// of the data operand per cycle. One request is worked on at a time; a new
// one is taken as soon as the previous result sits in the output register,
// and a result held back by m_ready stalls only the final hand-over.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user
// must write it only while no request is in flight, as the block itself
// does not enforce this. Writes to unknown indexes are dropped.
module pid_controller_with_rate_limit import pidrl_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IO_W-1:0]  s_error_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [IO_W-1:0]  m_drive,
    output logic                    m_settled
);

    localparam int AW = DATA_WIDTH + 2;

    localparam logic [63:0] DMAX_U   = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] DEAD_U   = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] NEAR_U   = ((64'd7 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] ILIM_RAW = 64'd100 << FRAC_BITS;
    localparam logic [63:0] ILIM_U   = (ILIM_RAW > DMAX_U) ? DMAX_U : ILIM_RAW;
    localparam logic [63:0] STEP_RAW = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] STEP_CAP = 64'd1 << DATA_WIDTH;
    localparam logic [63:0] STEP_U   = (STEP_RAW > STEP_CAP) ? STEP_CAP : STEP_RAW;

    localparam logic signed [63:0]   DMAX_S  = DMAX_U;
    localparam logic signed [63:0]   DMIN_S  = ~DMAX_S;
    localparam logic signed [AW-1:0] DMAX_A  = DMAX_U[AW-1:0];
    localparam logic signed [AW-1:0] DMIN_A  = ~DMAX_A;
    localparam logic signed [AW-1:0] ILIM_A  = ILIM_U[AW-1:0];
    localparam logic signed [AW-1:0] NILIM_A = -ILIM_A;
    localparam logic signed [AW-1:0] STEP_A  = STEP_U[AW-1:0];
    localparam logic signed [AW-1:0] NSTEP_A = -STEP_A;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LAUNCH, ST_WAIT, ST_LIMIT, ST_COUNT, ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        OP_INTEG, OP_SLOPE, OP_KEEP, OP_NEW, OP_PROP, OP_IGAIN, OP_DGAIN
    } op_t;

    function automatic logic signed [AW-1:0] ext_a(input logic signed [DATA_WIDTH-1:0] v);
        return {{2{v[DATA_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_a(input logic signed [AW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > DMAX_A) begin
            r = DMAX_A[DATA_WIDTH-1:0];
        end else if (v < DMIN_A) begin
            r = DMIN_A[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   ki_reg;
    logic [GAIN_W-1:0]   kd_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [GAIN_W-1:0]   inv_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // controller state and working registers
    state_t                       state_reg;
    op_t                          op_reg;
    logic signed [DATA_WIDTH-1:0] err_reg;
    logic signed [DATA_WIDTH-1:0] prev_reg;
    logic signed [DATA_WIDTH-1:0] integ_reg;
    logic signed [DATA_WIDTH-1:0] slope_reg;
    logic signed [DATA_WIDTH-1:0] fs_reg;
    logic signed [AW-1:0]         acc_reg;
    logic signed [DATA_WIDTH-1:0] last_drive_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic                         m_valid_reg;
    logic signed [IO_W-1:0]       m_drive_reg;
    logic                         m_settled_reg;

    // multiplier link
    mul_ctl_t                     mul_ctl;
    logic signed [DATA_WIDTH-1:0] mul_a;
    logic        [GAIN_W-1:0]     mul_g;
    logic                         mul_done;
    logic signed [DATA_WIDTH-1:0] mul_res;

    logic signed [DATA_WIDTH-1:0] err_sat;
    logic        [DATA_WIDTH-1:0] err_mag;
    logic signed [DATA_WIDTH-1:0] err_db;
    logic signed [DATA_WIDTH-1:0] diff;
    logic signed [AW-1:0]         r_a;
    logic signed [AW-1:0]         integ_sum;
    logic signed [DATA_WIDTH-1:0] integ_next;
    logic signed [DATA_WIDTH-1:0] fs_next;
    logic signed [AW-1:0]         acc_next;
    logic signed [DATA_WIDTH-1:0] drive_raw;
    logic signed [AW-1:0]         delta;
    logic signed [AW-1:0]         drive_lim;
    logic signed [DATA_WIDTH-1:0] last_drive_next;
    logic        [DATA_WIDTH-1:0] ld_mag;
    logic                         near_zero;

    // input conditioning: saturate to data range, then dead band
    always_comb begin
        if (64'(s_error_in) > DMAX_S) begin
            err_sat = DMAX_A[DATA_WIDTH-1:0];
        end else if (64'(s_error_in) < DMIN_S) begin
            err_sat = DMIN_A[DATA_WIDTH-1:0];
        end else begin
            err_sat = DATA_WIDTH'(s_error_in);
        end
        err_mag = err_sat[DATA_WIDTH-1] ? (~err_sat + DATA_WIDTH'(1)) : err_sat;
        err_db  = (64'(err_mag) < DEAD_U) ? '0 : err_sat;
    end

    // operand select for the shared multiplier
    always_comb begin
        diff           = sat_a(ext_a(err_reg) - ext_a(prev_reg));
        mul_a          = err_reg;
        mul_g          = '0;
        mul_ctl.start  = (state_reg == ST_LAUNCH);
        mul_ctl.narrow = 1'b0;
        unique case (op_reg)
            OP_INTEG: begin
                mul_a = err_reg;
                mul_g = GAIN_W'(period_reg);
            end
            OP_SLOPE: begin
                mul_a          = diff;
                mul_g          = inv_reg;
                mul_ctl.narrow = 1'b1;
            end
            OP_KEEP: begin
                mul_a = fs_reg;
                mul_g = W_KEEP;
            end
            OP_NEW: begin
                mul_a = slope_reg;
                mul_g = W_NEW;
            end
            OP_PROP: begin
                mul_a = err_reg;
                mul_g = kp_reg;
            end
            OP_IGAIN: begin
                mul_a = integ_reg;
                mul_g = ki_reg;
            end
            OP_DGAIN: begin
                mul_a = fs_reg;
                mul_g = kd_reg;
            end
            default: begin
                mul_a = err_reg;
                mul_g = '0;
            end
        endcase
    end

    // result combining, clamps and rate limit
    always_comb begin
        r_a       = ext_a(mul_res);
        integ_sum = ext_a(integ_reg) + r_a;
        if (integ_sum > ILIM_A) begin
            integ_next = ILIM_A[DATA_WIDTH-1:0];
        end else if (integ_sum < NILIM_A) begin
            integ_next = NILIM_A[DATA_WIDTH-1:0];
        end else begin
            integ_next = integ_sum[DATA_WIDTH-1:0];
        end
        acc_next  = acc_reg + r_a;
        fs_next   = sat_a(acc_next);

        drive_raw = sat_a(acc_reg);
        delta     = ext_a(drive_raw) - ext_a(last_drive_reg);
        priority if (delta > STEP_A) begin
            drive_lim = ext_a(last_drive_reg) + STEP_A;
        end else if (delta < NSTEP_A) begin
            drive_lim = ext_a(last_drive_reg) + NSTEP_A;
        end else begin
            drive_lim = ext_a(drive_raw);
        end
        last_drive_next = sat_a(drive_lim);

        ld_mag    = last_drive_reg[DATA_WIDTH-1] ? (~last_drive_reg + DATA_WIDTH'(1))
                                                 : last_drive_reg;
        near_zero = (64'(ld_mag) < NEAR_U);
    end

    pidrl_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .g       (mul_g),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= PROP_GAIN_RST;
            ki_reg         <= INTEG_GAIN_RST;
            kd_reg         <= DERIV_GAIN_RST;
            period_reg     <= PERIOD_RST;
            inv_reg        <= INV_PERIOD_RST;
            limit_reg      <= SETTLE_LIM_RST;
            state_reg      <= ST_IDLE;
            op_reg         <= OP_INTEG;
            err_reg        <= '0;
            prev_reg       <= '0;
            integ_reg      <= '0;
            slope_reg      <= '0;
            fs_reg         <= '0;
            acc_reg        <= '0;
            last_drive_reg <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_PROP_GAIN:  kp_reg     <= cfg_wdata[GAIN_W-1:0];
                    CFG_INTEG_GAIN: ki_reg     <= cfg_wdata[GAIN_W-1:0];
                    CFG_DERIV_GAIN: kd_reg     <= cfg_wdata[GAIN_W-1:0];
                    CFG_PERIOD:     period_reg <= cfg_wdata[PERIOD_W-1:0];
                    CFG_INV_PERIOD: inv_reg    <= cfg_wdata[GAIN_W-1:0];
                    CFG_SETTLE_LIM: limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (m_valid_reg && m_ready && (state_reg != ST_OUTPUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        err_reg   <= err_db;
                        op_reg    <= OP_INTEG;
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        unique case (op_reg)
                            OP_INTEG: integ_reg <= integ_next;
                            OP_SLOPE: slope_reg <= mul_res;
                            OP_KEEP:  acc_reg   <= r_a;
                            OP_NEW: begin
                                fs_reg   <= fs_next;
                                prev_reg <= err_reg;
                            end
                            OP_PROP:  acc_reg   <= r_a;
                            OP_IGAIN: acc_reg   <= acc_next;
                            OP_DGAIN: acc_reg   <= acc_next;
                            default: begin
                            end
                        endcase
                        if (op_reg == OP_DGAIN) begin
                            state_reg <= ST_LIMIT;
                        end else begin
                            op_reg    <= op_t'(op_reg + 3'd1);
                            state_reg <= ST_LAUNCH;
                        end
                    end
                end
                ST_LIMIT: begin
                    last_drive_reg <= last_drive_next;
                    state_reg      <= ST_COUNT;
                end
                ST_COUNT: begin
                    if (near_zero && (count_reg != COUNT_MAX)) begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    state_reg <= ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_drive_reg   <= IO_W'(last_drive_reg);
                        m_settled_reg <= (count_reg > limit_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_drive   = m_drive_reg;
    assign m_settled = m_settled_reg;

endmodule

// ===== rtl/core/pidrl_chk.sv =====
// Port-level checker for the rate-limited PID controller, bound to the top.
// No package dependency.
module pidrl_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_drive,
    input logic                m_settled
);

    // requests taken but not yet delivered
    logic [1:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            unique case ({s_valid && s_ready, m_valid && m_ready})
                2'b10:   pend_reg <= pend_reg + 2'd1;
                2'b01:   pend_reg <= pend_reg - 2'd1;
                default: pend_reg <= pend_reg;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_settled))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result without a request");

    a_idle_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> pend_reg < 2'd2)
        else $error("ready while two requests outstanding");

endmodule

bind pid_controller_with_rate_limit pidrl_chk u_pidrl_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_drive   (m_drive),
    .m_settled (m_settled)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for pid_controller_with_rate_limit: a queue-fed request driver,
// a result monitor and a bit-exact predictor of the control law, over several register settings.
// Depends on pidrl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench import pidrl_pkg::*;;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          LONG_HOLD   = 3000;
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_ITEMS = 100;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

    localparam longint D_MAX     = 64'sd2147483647;
    localparam longint D_MIN     = -64'sd2147483648;
    localparam longint DEAD_BAND = 64'sd3277;
    localparam longint INTEG_LIM = 64'sd6553600;
    localparam longint STEP_LIM  = 64'sd32768;
    localparam longint NEAR_BAND = 64'sd45875;

    typedef struct packed {
        logic signed [IO_W-1:0] drive;
        logic                   settled;
    } drive_res_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic signed [IO_W-1:0] s_error_in = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic signed [IO_W-1:0] m_drive;
    logic                   m_settled;

    logic signed [IO_W-1:0] error_backlog [$];
    drive_res_t             drive_due [$];
    int                     fail_count = 0;
    int                     cycle_count = 0;
    bit                     quiet = 1'b0;
    int                     hold_req = 0;
    int                     hold_seen = 0;
    int                     send_gap = 0;
    int                     hold_left = 0;

    // register copy
    logic [GAIN_W-1:0]   k_prop, k_integ, k_deriv, k_inv;
    logic [PERIOD_W-1:0] k_period;
    logic [LIMIT_W-1:0]  k_settle;

    // controller state copy
    longint              acc_integral, slope_filt, prev_err, held_drive;
    logic [COUNT_W-1:0]  low_drive_count;

    pid_controller_with_rate_limit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_error_in (s_error_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_settled  (m_settled)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp_data(longint v);
        if (v > D_MAX) return D_MAX;
        if (v < D_MIN) return D_MIN;
        return v;
    endfunction

    // (a * g) >> s, truncated toward zero, saturated
    function automatic longint scaled_product(longint a, longint unsigned g, int s);
        longint unsigned lim, m, hi, lo, r;
        bit neg;
        int up;
        neg = a < 0;
        lim = 64'h8000_0000;
        m   = neg ? longint'(-a) : longint'(a);
        g   = g & 64'hFF_FFFF;
        up  = 24 - s;
        if (m > lim) m = lim;
        hi = (m >> 24) * g;
        lo = (m & 64'hFF_FFFF) * g;
        if (hi > (lim >> up))
            r = lim;
        else
            r = (hi << up) + (lo >> s);
        if (r > lim) r = lim;
        return clamp_data(neg ? -longint'(r) : longint'(r));
    endfunction

    function automatic drive_res_t next_drive(logic signed [IO_W-1:0] err_in);
        longint err, slope, drv, delta, mag;
        drive_res_t res;
        err = longint'(err_in);
        if ((err < 0 ? -err : err) < DEAD_BAND) err = 0;

        acc_integral = clamp_data(acc_integral + scaled_product(err, k_period, QF_GAIN));
        if (acc_integral > INTEG_LIM) acc_integral = INTEG_LIM;
        if (acc_integral < -INTEG_LIM) acc_integral = -INTEG_LIM;

        slope = scaled_product(clamp_data(err - prev_err), k_inv, QF_INV);
        slope_filt = clamp_data(scaled_product(slope_filt, W_KEEP, QF_GAIN)
                                + scaled_product(slope, W_NEW, QF_GAIN));
        prev_err = err;

        drv = clamp_data(scaled_product(err, k_prop, QF_GAIN)
                         + scaled_product(acc_integral, k_integ, QF_GAIN)
                         + scaled_product(slope_filt, k_deriv, QF_GAIN));
        delta = drv - held_drive;
        if (delta > STEP_LIM) drv = held_drive + STEP_LIM;
        if (delta < -STEP_LIM) drv = held_drive - STEP_LIM;
        held_drive = clamp_data(drv);

        mag = held_drive < 0 ? -held_drive : held_drive;
        if (mag < NEAR_BAND && low_drive_count < COUNT_MAX)
            low_drive_count = low_drive_count + 1'b1;

        res.drive   = held_drive[IO_W-1:0];
        res.settled = low_drive_count > k_settle;
        return res;
    endfunction

    function automatic logic signed [IO_W-1:0] pick_error();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            v = int'($urandom_range(0, 393216)) - 196608;
        end else if (sel < 55) begin
            v = 3277 + int'($urandom_range(0, 16)) - 8;
            if ($urandom_range(0, 1)) v = -v;
        end else if (sel < 70) begin
            v = int'($urandom);
        end else if (sel < 80) begin
            case ($urandom_range(0, 3))
                0: v = 32'sh7FFF_FFFF;
                1: v = 32'sh8000_0000;
                2: v = 6553600;
                default: v = -6553600;
            endcase
        end else begin
            v = int'($urandom_range(0, 33554432)) - 16777216;
        end
        return v;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PROP_GAIN:  k_prop   = val;
            CFG_INTEG_GAIN: k_integ  = val;
            CFG_DERIV_GAIN: k_deriv  = val;
            CFG_PERIOD:     k_period = val[PERIOD_W-1:0];
            CFG_INV_PERIOD: k_inv    = val;
            CFG_SETTLE_LIM: k_settle = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] pg, logic [CFG_DATA_W-1:0] ig,
                             logic [CFG_DATA_W-1:0] dg, logic [CFG_DATA_W-1:0] per,
                             logic [CFG_DATA_W-1:0] inv, logic [CFG_DATA_W-1:0] lim);
        write_reg(CFG_PROP_GAIN, pg);
        write_reg(CFG_INTEG_GAIN, ig);
        write_reg(CFG_DERIV_GAIN, dg);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_INV_PERIOD, inv);
        write_reg(CFG_SETTLE_LIM, lim);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  CFG_DATA_W'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (error_backlog.size() != 0 || s_valid || drive_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 24'h03_0000));
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                drive_due.push_back(next_drive(s_error_in));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (error_backlog.size() != 0) begin
                    s_valid    <= 1'b1;
                    s_error_in <= error_backlog.pop_front();
                    if (!quiet && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        drive_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result drive=%0d settled=%0b",
                             $time, m_drive, m_settled);
                end else begin
                    want = drive_due.pop_front();
                    if (m_drive !== want.drive) begin
                        fail_count++;
                        $display("%0t: drive mismatch expected %0d actual %0d",
                                 $time, want.drive, m_drive);
                    end
                    if (m_settled !== want.settled) begin
                        fail_count++;
                        $display("%0t: settled mismatch expected %0b actual %0b",
                                 $time, want.settled, m_settled);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n;
        int run;
        k_prop          = PROP_GAIN_RST;
        k_integ         = INTEG_GAIN_RST;
        k_deriv         = DERIV_GAIN_RST;
        k_period        = PERIOD_RST;
        k_inv           = INV_PERIOD_RST;
        k_settle        = SETTLE_LIM_RST;
        acc_integral    = 0;
        slope_filt      = 0;
        prev_err        = 0;
        held_drive      = 0;
        low_drive_count = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults first, then the corner values
        error_backlog = '{0, 0, 0, 0, 3276, -3276, 3277, -3277};
        wait_drained();
        write_all(24'h01_0000, 24'h02_0000, 24'h00_4000, 24'd655, 24'd25600, 24'd2);
        error_backlog = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1,
                          45875, -45875, 65536, -65536, 6553600, 32'sh8000_0000,
                          0, 0, 0};
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                             24'hFF_FFFF, 24'h00_0000);
                1: write_all(24'h00_0000, 24'h00_0000, 24'h00_0000, 24'h00_0000,
                             24'h00_0000, 24'h00_FFFF);
                2: write_all(24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd65535);
                default: write_all(pick_gain(), pick_gain(), pick_gain(),
                                   $urandom_range(0, 3) == 0 ?
                                       CFG_DATA_W'($urandom) :
                                       CFG_DATA_W'($urandom_range(1, 2000)),
                                   $urandom_range(0, 3) == 0 ?
                                       CFG_DATA_W'($urandom) :
                                       CFG_DATA_W'($urandom_range(1000, 60000)),
                                   CFG_DATA_W'($urandom_range(0, 40)));
            endcase
            if (p == RAND_PHASES - 1) quiet = 1'b1;
            if (p == 4) hold_req++;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // run of dead-band errors to let the drive decay and settle
                    run = $urandom_range(5, 40);
                    repeat (run) error_backlog.push_back(int'($urandom_range(0, 6552)) - 3276);
                    n += run;
                end else begin
                    error_backlog.push_back(pick_error());
                    n++;
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pidrl_pkg.sv
rtl/core/pidrl_mul.sv
rtl/core/pid_controller_with_rate_limit.sv
rtl/core/pidrl_chk.sv
tb/testbench.sv
